// ----- design/rbct_pkg.sv -----
// rbct_pkg: shared constants and types for the random bin co-occupancy trial block.
// Holds generator constants, register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package rbct_pkg;

   // Default slot memory depth
   localparam int MAX_SLOTS_DEF = 1024;

   // 48-bit linear congruential generator
   localparam logic [34:0] GEN_MUL  = 35'h5DEECE66D;
   localparam logic [47:0] GEN_ADD  = 48'h00000000000B;
   localparam logic [15:0] SEED_LOW = 16'h330E;

   // Field widths
   localparam int CNT_W   = 11;
   localparam int MARB_W  = 16;
   localparam int SUM_W   = 40;
   localparam int TALLY_W = 32;
   localparam int SEED_W  = 32;
   localparam int IDX_W   = 3;

   // Reset values of the registers
   localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

   // Register indexes on the control port
   typedef enum logic [IDX_W-1:0] {
      REG_SLOT_COUNT     = 3'd0,
      REG_RED_COUNT      = 3'd1,
      REG_BLACK_COUNT    = 3'd2,
      REG_OBSERVED_COUNT = 3'd3,
      REG_SEED           = 3'd4
   } reg_index_type;

endpackage

// ----- design/random_bin_cooccupancy_trial_top.sv -----
// Steps from accept to result: clear the M mark slots, where M is the clamped slot count, draw
// the red then the black marbles, and scan the M slots; with either marble count zero the
// trial goes straight to finish. One trial is in work at a time. Each draw is three 16-bit
// limb products of the generator step, one scaling multiply and one mark write.
// A new request is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) restores control, settings and totals; marks need no reset pass.
// Top level of the random bin co-occupancy trial block.
// Depends on rbct_pkg.
`timescale 1ns / 1ps

module random_bin_cooccupancy_trial_top
   import rbct_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] clear_totals, [7:1] zero
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // [10:0] double_count, [11] at_most_observed,
                                     // [12] at_least_observed, [52:13] double_sum,
                                     // [84:53] at_most_tally, [116:85] at_least_tally,
                                     // [148:117] trial_tally, [151:149] zero
   // control register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [SEED_W-1:0] csr_data
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int MW = $clog2(MAX_SLOTS + 1);
   localparam int HW = 32 + MW;
   localparam int LW = 16 + MW;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CLEAR  = 8'b00000010,
      ST_GEN    = 8'b00000100,
      ST_SCALE  = 8'b00001000,
      ST_MARK   = 8'b00010000,
      ST_SCAN   = 8'b00100000,
      ST_DRAIN  = 8'b01000000,
      ST_FINISH = 8'b10000000
   } state_type;

   // Configuration registers
   logic [CNT_W-1:0]  slot_count_ff;
   logic [MARB_W-1:0] red_count_ff;
   logic [MARB_W-1:0] black_count_ff;
   logic [CNT_W-1:0]  observed_ff;

   // Control and datapath registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [MW-1:0]     m_ff, m_in;
   logic              clr_tot_ff, clr_tot_in;
   logic              skip_ff, skip_in;
   logic              color_ff, color_in;
   logic [MARB_W-1:0] k_ff, k_in;
   logic [1:0]        limb_ff, limb_in;
   logic [47:0]       acc_ff, acc_in;
   logic [47:0]       gen_ff;
   logic [HW-1:0]     hi_prod_ff;
   logic [LW-1:0]     lo_prod_ff;
   logic              rd_pend_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Running totals
   logic [SUM_W-1:0]   sum_ff;
   logic [TALLY_W-1:0] le_tally_ff, ge_tally_ff, trial_tally_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [148:0]       rsp_data_ff;

   // Mark memories
   logic               red_mem   [MAX_SLOTS];
   logic               black_mem [MAX_SLOTS];
   logic               red_q_ff, black_q_ff;
   logic               red_we, black_we, wr_bit;
   logic [AW-1:0]      wr_addr;

   // Combinational helpers
   logic               req_xfer, rsp_free;
   logic [MW-1:0]      eff_m;
   logic               last_addr;
   logic [15:0]        x_limb;
   logic [50:0]        pp_full;
   logic [47:0]        pp_shift;
   logic [HW-1:0]      slot_sum;
   logic [AW-1:0]      slot;
   logic [MARB_W-1:0]  k_target;
   logic               le_flag, ge_flag;
   logic [SUM_W-1:0]   base_sum;
   logic [TALLY_W-1:0] base_le, base_ge, base_trial;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   new_sum;
   logic [TALLY_W-1:0] new_le, new_ge, new_trial;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Clamp the slot count into [1, MAX_SLOTS]
   always_comb begin
      if (slot_count_ff == '0) begin
         eff_m = MW'(1);
      end else if (32'(slot_count_ff) > 32'(MAX_SLOTS)) begin
         eff_m = MW'(MAX_SLOTS);
      end else begin
         eff_m = MW'(slot_count_ff);
      end
   end

   assign last_addr = ((32'(addr_ff) + 32'd1) == 32'(m_ff));

   // One 16-bit limb product of the generator step per cycle
   always_comb begin
      case (limb_ff)
         2'd0:    x_limb = gen_ff[15:0];
         2'd1:    x_limb = gen_ff[31:16];
         default: x_limb = gen_ff[47:32];
      endcase
      pp_full = 51'(GEN_MUL) * 51'(x_limb);
      case (limb_ff)
         2'd0:    pp_shift = pp_full[47:0];
         2'd1:    pp_shift = {pp_full[31:0], 16'h0000};
         default: pp_shift = {pp_full[15:0], 32'h00000000};
      endcase
   end

   // Slot = (X * M) >> 48 from the two registered partial products
   assign slot_sum = hi_prod_ff + HW'(lo_prod_ff >> 16);
   assign slot     = slot_sum[32 +: AW];
   assign k_target = color_ff ? black_count_ff : red_count_ff;

   // Totals for the finishing trial
   always_comb begin
      le_flag    = !skip_ff && (count_ff <= observed_ff);
      ge_flag    = !skip_ff && (count_ff >= observed_ff);
      base_sum   = clr_tot_ff ? '0 : sum_ff;
      base_le    = clr_tot_ff ? '0 : le_tally_ff;
      base_ge    = clr_tot_ff ? '0 : ge_tally_ff;
      base_trial = clr_tot_ff ? '0 : trial_tally_ff;
      sum_add    = {1'b0, base_sum} + (SUM_W + 1)'(count_ff);
      new_sum    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      new_le     = (le_flag && (base_le != '1)) ? base_le + 1'b1 : base_le;
      new_ge     = (ge_flag && (base_ge != '1)) ? base_ge + 1'b1 : base_ge;
      new_trial  = (base_trial != '1) ? base_trial + 1'b1 : base_trial;
   end

   // Sequencer: clear, draw red, draw black, scan, finish; a missing color goes straight to finish
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      m_in       = m_ff;
      clr_tot_in = clr_tot_ff;
      skip_in    = skip_ff;
      color_in   = color_ff;
      k_in       = k_ff;
      limb_in    = limb_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      red_we     = 1'b0;
      black_we   = 1'b0;
      wr_bit     = 1'b0;
      wr_addr    = addr_ff;
      if (rd_pend_ff && red_q_ff && black_q_ff) begin
         count_in = count_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               m_in       = eff_m;
               clr_tot_in = req_tdata[0];
               count_in   = '0;
               addr_in    = '0;
               if (red_count_ff == '0 || black_count_ff == '0) begin
                  skip_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  skip_in  = 1'b0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            red_we   = 1'b1;
            black_we = 1'b1;
            addr_in  = addr_ff + 1'b1;
            if (last_addr) begin
               color_in = 1'b0;
               k_in     = '0;
               limb_in  = 2'd0;
               acc_in   = GEN_ADD;
               state_in = ST_GEN;
            end
         end
         ST_GEN: begin
            acc_in  = acc_ff + pp_shift;
            limb_in = limb_ff + 1'b1;
            if (limb_ff == 2'd2) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_MARK;
         end
         ST_MARK: begin
            wr_addr  = slot;
            wr_bit   = 1'b1;
            red_we   = !color_ff;
            black_we = color_ff;
            k_in     = k_ff + 1'b1;
            limb_in  = 2'd0;
            acc_in   = GEN_ADD;
            state_in = ST_GEN;
            if (k_ff == k_target - 1'b1) begin
               k_in = '0;
               if (color_ff) begin
                  addr_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  color_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SCAN);
      end
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      m_ff       <= m_in;
      clr_tot_ff <= clr_tot_in;
      skip_ff    <= skip_in;
      color_ff   <= color_in;
      k_ff       <= k_in;
      limb_ff    <= limb_in;
      acc_ff     <= acc_in;
      count_ff   <= count_in;
      if (state_ff == ST_SCALE) begin
         hi_prod_ff <= HW'(gen_ff[47:16]) * HW'(m_ff);
         lo_prod_ff <= LW'(gen_ff[15:0]) * LW'(m_ff);
      end
   end

   // Generator state: load on seed write, step after the last limb
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= {32'h00000000, SEED_LOW};
      end else if (csr_valid && csr_ready && csr_index == REG_SEED) begin
         gen_ff <= {csr_data, SEED_LOW};
      end else if (state_ff == ST_GEN && limb_ff == 2'd2) begin
         gen_ff <= acc_in;
      end
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= SLOT_COUNT_RST;
         red_count_ff   <= '0;
         black_count_ff <= '0;
         observed_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SLOT_COUNT:     slot_count_ff  <= csr_data[CNT_W-1:0];
            REG_RED_COUNT:      red_count_ff   <= csr_data[MARB_W-1:0];
            REG_BLACK_COUNT:    black_count_ff <= csr_data[MARB_W-1:0];
            REG_OBSERVED_COUNT: observed_ff    <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Mark memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (red_we) begin
         red_mem[wr_addr] <= wr_bit;
      end
      red_q_ff <= red_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (black_we) begin
         black_mem[wr_addr] <= wr_bit;
      end
      black_q_ff <= black_mem[addr_ff];
   end

   // Update totals and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff         <= '0;
         le_tally_ff    <= '0;
         ge_tally_ff    <= '0;
         trial_tally_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && rsp_free) begin
            sum_ff         <= new_sum;
            le_tally_ff    <= new_le;
            ge_tally_ff    <= new_ge;
            trial_tally_ff <= new_trial;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_data_ff <= {new_trial, new_ge, new_le, new_sum, ge_flag, le_flag, count_ff};
      end
   end

   // Checks
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (32'(slot) < 32'(m_ff)))
      else $error("drawn slot outside the slots in use");

   a_result_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[148:117] != '0))
      else $error("result shown with zero trial tally");

   a_no_flags_no_doubles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[11] && !rsp_data_ff[12]) |-> (rsp_data_ff[10:0] == '0))
      else $error("skipped trial reports doubles");

   a_totals_follow_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FINISH) |=> $stable(trial_tally_ff))
      else $error("trial tally moved outside finish");

endmodule

// ----- bench/tb_random_bin_cooccupancy_trial_top.sv -----
// tb_random_bin_cooccupancy_trial_top: self-checking bench for the co-occupancy trial block.
// Predicts each trial with its own generator, marks and totals and checks every result stream
// transfer against it. Depends on rbct_pkg and random_bin_cooccupancy_trial_top.
`timescale 1ns / 1ps

module tb_random_bin_cooccupancy_trial_top;
   import rbct_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int SLOT_LIMIT = MAX_SLOTS_DEF;
   localparam logic [47:0] LCG_MULT = 48'h0005DEECE66D;
   localparam logic [47:0] LCG_INC = 48'h00000000000B;
   localparam logic [15:0] SEED_TAIL = 16'h330E;
   localparam logic [IDX_W-1:0] FIRST_UNUSED_INDEX = IDX_W'(REG_SEED + 1);
   localparam int RANDOM_TRIALS = 110;
   localparam int SETTLE_CYCLES = 200;

   // Result word, last field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [31:0] trial_tally;
      logic [31:0] at_least_tally;
      logic [31:0] at_most_tally;
      logic [39:0] double_sum;
      logic        at_least;
      logic        at_most;
      logic [10:0] double_count;
   } trial_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [SEED_W-1:0] csr_data = '0;

   // Predicted configuration and state of the block
   logic [10:0] slots_cfg = 11'd1024;
   logic [15:0] red_cfg = '0;
   logic [15:0] black_cfg = '0;
   logic [10:0] observed_cfg = '0;
   logic [47:0] lcg_state = {32'h0, SEED_TAIL};
   logic [SLOT_LIMIT-1:0] red_marks = '0;
   logic [SLOT_LIMIT-1:0] black_marks = '0;
   logic [39:0] doubles_total = '0;
   logic [31:0] low_side_count = '0;
   logic [31:0] high_side_count = '0;
   logic [31:0] trial_count = '0;

   trial_result_type pending_results[$];
   int error_count = 0;
   bit idling_on = 1'b1;
   int unsigned rsp_hold_left = 0;

   random_bin_cooccupancy_trial_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // Step the generator and scale it into [0, m)
   function automatic int unsigned draw_slot(int unsigned m);
      logic [63:0] scaled;
      lcg_state = lcg_state * LCG_MULT + LCG_INC;
      scaled = 64'(lcg_state) * 64'(m);
      return 32'(scaled[63:48]);
   endfunction

   // Run one trial on the predicted state and return the result it reports
   function automatic trial_result_type run_trial(logic clear);
      trial_result_type res;
      int unsigned m;
      int unsigned hits;
      logic [40:0] wide_sum;
      res = '0;
      if (clear) begin
         doubles_total = '0;
         low_side_count = '0;
         high_side_count = '0;
         trial_count = '0;
      end
      m = 32'(slots_cfg);
      if (m < 1) m = 1;
      if (m > SLOT_LIMIT) m = SLOT_LIMIT;
      hits = 0;
      // no draws at all when either color is missing
      if (red_cfg != 0 && black_cfg != 0) begin
         red_marks = '0;
         black_marks = '0;
         repeat (red_cfg) red_marks[draw_slot(m)] = 1'b1;
         repeat (black_cfg) black_marks[draw_slot(m)] = 1'b1;
         for (int s = 0; s < m; s++) begin
            if (red_marks[s] && black_marks[s]) hits++;
         end
         res.at_most = (hits <= observed_cfg);
         res.at_least = (hits >= observed_cfg);
         wide_sum = doubles_total + hits;
         doubles_total = wide_sum[40] ? '1 : wide_sum[39:0];
         if (res.at_most && low_side_count != '1) low_side_count++;
         if (res.at_least && high_side_count != '1) high_side_count++;
      end
      if (trial_count != '1) trial_count++;
      res.double_count = 11'(hits);
      res.double_sum = doubles_total;
      res.at_most_tally = low_side_count;
      res.at_least_tally = high_side_count;
      res.trial_tally = trial_count;
      return res;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Drop the request, hold until no trial is in flight, then write one register and mirror
   // it into the prediction; leave csr_valid to the next step
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [SEED_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SLOT_COUNT:     slots_cfg = value[10:0];
         REG_RED_COUNT:      red_cfg = value[15:0];
         REG_BLACK_COUNT:    black_cfg = value[15:0];
         REG_OBSERVED_COUNT: observed_cfg = value[10:0];
         REG_SEED:           lcg_state = {value, SEED_TAIL};
         default: ;
      endcase
   endtask

   task automatic set_trial(int unsigned slots, int unsigned red, int unsigned black,
                            int unsigned observed);
      write_reg(REG_SLOT_COUNT, slots);
      write_reg(REG_RED_COUNT, red);
      write_reg(REG_BLACK_COUNT, black);
      write_reg(REG_OBSERVED_COUNT, observed);
   endtask

   // Offer one trial request, with a random gap ahead of it when idling is on
   task automatic send_trial(logic clear);
      csr_valid <= 1'b0;
      if (idling_on && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, clear};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(run_trial(clear));
   endtask

   // Drop the request and hold until every predicted result has been taken
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Accept results with random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin : result_side
      trial_result_type got;
      trial_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = trial_result_type'(rsp_tdata);
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("double_count", 64'(want.double_count), 64'(got.double_count));
            check_field("at_most_observed", 64'(want.at_most), 64'(got.at_most));
            check_field("at_least_observed", 64'(want.at_least), 64'(got.at_least));
            check_field("double_sum", 64'(want.double_sum), 64'(got.double_sum));
            check_field("at_most_tally", 64'(want.at_most_tally), 64'(got.at_most_tally));
            check_field("at_least_tally", 64'(want.at_least_tally),
                        64'(got.at_least_tally));
            check_field("trial_tally", 64'(want.trial_tally), 64'(got.trial_tally));
            check_field("padding", 64'(want.pad), 64'(got.pad));
         end
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idling_on && $urandom_range(0, 99) < 28);
      end
   end

   // Registers at their reset values: no marbles, so only the trial count moves
   task automatic test_reset_values();
      send_trial(1'b0);
      wait_all_results();
   endtask

   // One color missing: no draws, flags clear, totals other than trials held
   task automatic test_zero_marbles();
      set_trial(1024, 65535, 0, 0);
      send_trial(1'b0);
      write_reg(REG_RED_COUNT, 0);
      write_reg(REG_BLACK_COUNT, 65535);
      send_trial(1'b1);
      wait_all_results();
   endtask

   // Single slot, slot count zero used as one, observed count at both ends
   task automatic test_single_slot();
      set_trial(0, 1, 1, 1);
      send_trial(1'b1);
      write_reg(REG_OBSERVED_COUNT, 0);
      send_trial(1'b0);
      write_reg(REG_OBSERVED_COUNT, 2047);
      send_trial(1'b0);
      write_reg(REG_SLOT_COUNT, 1);
      send_trial(1'b0);
      wait_all_results();
   endtask

   // Slot counts above the memory depth are clamped to it
   task automatic test_slot_clamp();
      set_trial(2047, 600, 600, 1024);
      send_trial(1'b1);
      write_reg(REG_SLOT_COUNT, 1025);
      write_reg(REG_OBSERVED_COUNT, 0);
      send_trial(1'b0);
      write_reg(REG_SLOT_COUNT, 1024);
      send_trial(1'b0);
      wait_all_results();
   endtask

   // Seed writes reload the generator; the same seed repeats the sequence
   task automatic test_seed_load();
      set_trial(64, 20, 20, 5);
      write_reg(REG_SEED, 32'hFFFF_FFFF);
      send_trial(1'b1);
      send_trial(1'b0);
      write_reg(REG_SEED, 32'h0);
      send_trial(1'b0);
      write_reg(REG_SEED, 32'hFFFF_FFFF);
      send_trial(1'b0);
      wait_all_results();
   endtask

   // Writes to unused indexes change nothing
   task automatic test_unknown_index();
      for (int i = FIRST_UNUSED_INDEX; i < 2 ** IDX_W; i++) write_reg(IDX_W'(i), $urandom);
      send_trial(1'b0);
      wait_all_results();
   endtask

   // A full-range red count and a large black count run the draw loops to their ends
   task automatic test_heavy_draws();
      set_trial(1024, 65535, 1, 0);
      send_trial(1'b1);
      write_reg(REG_RED_COUNT, 1);
      write_reg(REG_BLACK_COUNT, 4096);
      write_reg(REG_OBSERVED_COUNT, 1);
      send_trial(1'b0);
      wait_all_results();
   endtask

   // Clearing restarts the running totals mid-stream
   task automatic test_clear_totals();
      set_trial(16, 8, 8, 2);
      send_trial(1'b0);
      send_trial(1'b1);
      send_trial(1'b0);
      send_trial(1'b0);
      send_trial(1'b1);
      wait_all_results();
   endtask

   // Stall the result side long enough for the block to back up into its input
   task automatic test_backpressure();
      set_trial(4, 3, 3, 1);
      rsp_hold_left = 2000;
      repeat (8) send_trial(1'b0);
      wait_all_results();
   endtask

   // Random settings per phase, mostly small trials, with two phases free of idling
   task automatic test_random_trials();
      int unsigned sent;
      int unsigned phase;
      int unsigned burst;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_TRIALS) begin
         idling_on = !(phase == 3 || phase == 4);
         case ($urandom_range(0, 9))
            0:       write_reg(REG_SLOT_COUNT, 0);
            1:       write_reg(REG_SLOT_COUNT, $urandom_range(1025, 2047));
            2:       write_reg(REG_SLOT_COUNT, $urandom_range(256, 1024));
            default: write_reg(REG_SLOT_COUNT, $urandom_range(1, 64));
         endcase
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_RED_COUNT, ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 40));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_BLACK_COUNT, ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 40));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_OBSERVED_COUNT,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, 6));
         if ($urandom_range(0, 9) < 3) write_reg(REG_SEED, $urandom);
         if ($urandom_range(0, 9) == 0)
            write_reg(IDX_W'($urandom_range(FIRST_UNUSED_INDEX, 2 ** IDX_W - 1)), $urandom);
         burst = $urandom_range(4, 12);
         repeat (burst) send_trial($urandom_range(0, 9) == 0);
         sent += burst;
         phase++;
         wait_all_results();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_zero_marbles();
      test_single_slot();
      test_slot_clamp();
      test_seed_load();
      test_unknown_index();
      test_heavy_draws();
      test_clear_totals();
      test_backpressure();
      test_random_trials();
      wait_all_results();
      // catch any stray result after the last one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Bound the run well beyond the slowest legal schedule
   initial begin
      #64_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/rbct_pkg.sv
design/random_bin_cooccupancy_trial_top.sv
bench/tb_random_bin_cooccupancy_trial_top.sv
